// ===== src/exsort_pkg.sv =====
// Package for the exchange sorter: key width, controller states and the
// ordering compare. Used by exchange_sorter_unit; depends on nothing.
`timescale 1ns / 1ps

package exsort_pkg;

    localparam int KEY_W = 32;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // True when the key held at the lower position must be exchanged with a later one.
    function automatic logic out_of_order(input key_t a, input key_t b, input logic desc);
        logic result;
        if (desc)
        begin
            result = $signed(b) > $signed(a);
        end
        else
        begin
            result = $signed(a) > $signed(b);
        end
        return result;
    endfunction

endpackage

// ===== src/exchange_sorter_unit.sv =====
// Exchange sorter top level: collects keys into a synchronous store and
// emits them sorted once the last key of a set arrives. Depends on exsort_pkg.
// Keys are taken one per cycle while collecting. The sort makes one store read
// per compare and writes each settled key back to its output position. Each
// sorted item leaves once its position is settled and the output register is
// free. Reset clears the key count, the overflow flag and the order bit; the key
// store is not cleared.
`timescale 1ns / 1ps

module exchange_sorter_unit
    import exsort_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // sort_descending
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // key_value
    input  logic        s_tlast,       // set_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // sorted_key
    output logic        m_tlast,       // final_key
    output logic        m_tuser        // overflowed
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    key_t key_store [DEPTH];

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic           desc_reg;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic           pend_valid_reg, pend_valid_next;
    logic           pend_first_reg, pend_first_next;
    logic [AW-1:0]  pend_idx_reg, pend_idx_next;
    key_t           cur_reg, cur_next;
    key_t           rdata_reg;
    logic           out_valid_reg, out_valid_next;
    key_t           out_key_reg, out_key_next;
    logic           out_last_reg, out_last_next;
    logic           out_ovf_reg, out_ovf_next;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    key_t           mem_wdata;
    logic [AW-1:0]  rd_addr;
    logic           issue;
    logic           out_free;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_store[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= key_store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            desc_reg       <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                desc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_first_reg <= pend_first_next;
        pend_idx_reg   <= pend_idx_next;
        cur_reg        <= cur_next;
        out_key_reg    <= out_key_next;
        out_last_reg   <= out_last_next;
        out_ovf_reg    <= out_ovf_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        pend_valid_next = 1'b0;
        pend_first_next = pend_first_reg;
        pend_idx_next   = pend_idx_reg;
        cur_next        = cur_reg;
        out_key_next    = out_key_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = s_tdata;
        rd_addr         = j_reg[AW-1:0];
        issue           = 1'b0;
        s_tready        = 1'b0;
        out_free        = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (count_reg < DEPTH_C)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                issue = j_reg < count_reg;
                if (issue)
                begin
                    j_next          = j_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_first_next = j_reg == i_reg;
                    pend_idx_next   = j_reg[AW-1:0];
                end
                if (pend_valid_reg)
                begin
                    if (pend_first_reg)
                    begin
                        cur_next = rdata_reg;
                    end
                    else if (out_of_order(cur_reg, rdata_reg, desc_reg))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_idx_reg;
                        mem_wdata = cur_reg;
                        cur_next  = rdata_reg;
                    end
                end
                if (!issue && !pend_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = i_reg[AW-1:0];
                    mem_wdata      = cur_reg;
                    out_valid_next = 1'b1;
                    out_key_next   = cur_reg;
                    out_last_next  = (i_reg + 1'b1) == count_reg;
                    out_ovf_next   = ovf_reg;
                    if ((i_reg + 1'b1) == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        j_next     = i_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_key_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

// ===== tb/tb_exchange_sorter_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for exchange_sorter_unit: streams sets of signed keys
// under random idling and back-pressure and checks every sorted item against a
// predictor. Depends on exsort_pkg and exchange_sorter_unit.

typedef struct packed {
    exsort_pkg::key_t key;
    logic             last;
    logic             ovf;
} sorted_item_t;

class sort_scoreboard #(int DEPTH = 32);
    exsort_pkg::key_t held_keys[DEPTH];
    int unsigned      held_count;
    bit               dropped;
    bit               descending;
    sorted_item_t     expected_q[$];
    int               errors;

    function new();
        held_count = 0;
        dropped    = 0;
        descending = 0;
        errors     = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(input string msg);
        if (errors < 40)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        errors++;
    endtask

    // Stores the key and, on the final key of a set, sorts and queues the results.
    function void note_input(input exsort_pkg::key_t key, input logic last);
        exsort_pkg::key_t tmp;
        sorted_item_t     item;
        bit               swap;
        if (held_count < DEPTH)
        begin
            held_keys[held_count] = key;
            held_count++;
        end
        else
        begin
            dropped = 1;
        end
        if (last)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                for (int j = i + 1; j < held_count; j++)
                begin
                    swap = descending ? ($signed(held_keys[j]) > $signed(held_keys[i]))
                                      : ($signed(held_keys[i]) > $signed(held_keys[j]));
                    if (swap)
                    begin
                        tmp          = held_keys[i];
                        held_keys[i] = held_keys[j];
                        held_keys[j] = tmp;
                    end
                end
            end
            for (int k = 0; k < held_count; k++)
            begin
                item.key  = held_keys[k];
                item.last = (k == held_count - 1);
                item.ovf  = dropped;
                expected_q.push_back(item);
            end
            held_count = 0;
            dropped    = 0;
        end
    endfunction

    task check_result(input exsort_pkg::key_t key, input logic last, input logic ovf);
        sorted_item_t want;
        if (expected_q.size() == 0)
        begin
            report($sformatf("unexpected item key=%0d last=%b ovf=%b", $signed(key), last, ovf));
        end
        else
        begin
            want = expected_q.pop_front();
            if (key !== want.key)
            begin
                report($sformatf("key %0d, expected %0d", $signed(key), $signed(want.key)));
            end
            if (last !== want.last)
            begin
                report($sformatf("last %b, expected %b", last, want.last));
            end
            if (ovf !== want.ovf)
            begin
                report($sformatf("overflow %b, expected %b", ovf, want.ovf));
            end
        end
    endtask
endclass

module tb_exchange_sorter_unit;
    import exsort_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 40;
    localparam int RANDOM_KEYS = 340;

    localparam int STYLE_FULL    = 0;
    localparam int STYLE_NARROW  = 1;
    localparam int STYLE_EXTREME = 2;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // key_value
    logic        s_tlast;     // set_end
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // sorted_key
    logic        m_tlast;     // final_key
    logic        m_tuser;     // overflowed

    sort_scoreboard #(DEPTH) sb;
    bit tx_idle;
    bit rx_idle;
    int hold_cycles;
    int keys_sent;
    int cycle_count;

    exchange_sorter_unit #(.DEPTH(DEPTH)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Result side: a random stall before each item, or a long hold when one is requested.
    initial
    begin : sink_proc
        int wait_cycles;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                wait_cycles = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                wait_cycles = rx_idle ? $urandom_range(0, 11) : 0;
            end
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_key(input key_t key, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(key, last);
        keys_sent++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_order(input logic desc);
        wait_results();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= desc;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.descending = desc;
    endtask

    function automatic key_t pick_key(input int style);
        key_t key;
        case (style)
            STYLE_FULL:    key = $urandom();
            STYLE_NARROW:  key = key_t'($urandom_range(0, 16) - 8);
            STYLE_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       key = 32'h8000_0000;
                    1:       key = 32'h7FFF_FFFF;
                    2:       key = 32'h0000_0000;
                    3:       key = 32'hFFFF_FFFF;
                    default: key = $urandom();
                endcase
            end
            default:       key = $urandom();
        endcase
        return key;
    endfunction

    task automatic send_set(input int n);
        int style;
        style = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
        begin
            send_key(pick_key(style), i == n - 1);
        end
    endtask

    task automatic send_directed();
        send_key(32'h8000_0000, 1'b1);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b0);
        send_key(32'h0000_0001, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b1);
        send_key(32'd5, 1'b0);
        send_key(-32'sd5, 1'b0);
        send_key(32'd5, 1'b0);
        send_key(32'd5, 1'b1);
    endtask

    initial
    begin : stimulus
        int phase_end;
        int n;
        sb          = new();
        tx_idle     = 0;
        rx_idle     = 0;
        hold_cycles = 0;
        keys_sent   = 0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_order(1'b0);
        send_directed();
        write_order(1'b1);
        tx_idle = 1;
        rx_idle = 1;
        send_directed();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_order(phase[0]);
            phase_end = keys_sent + RANDOM_KEYS / 4;
            if (phase == 1)
            begin
                // Hold the result side so that the sorter stalls its input.
                tx_idle = 0;
                hold_cycles = 700;
                send_set(20);
                send_set(6);
            end
            if (phase == 2)
            begin
                // Full store, one key over, and a final key dropped while full.
                send_set(DEPTH);
                send_set(DEPTH + 1);
                send_set(DEPTH + 3);
                wait_results();
            end
            while (keys_sent < phase_end)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 8)
                                                : $urandom_range(1, 8);
                send_set(n);
            end
        end

        wait_results();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
